FILE: rtl/sbsf_pkg.sv
// ----------------------------------------------------------------------------
// sbsf_pkg: shared types and constants of the stencil blur/sobel filter
// Register indexes, field widths and the command passed from the front
// end to the back end through the command queue.
// ----------------------------------------------------------------------------
package sbsf_pkg;

	// fixed field widths
	localparam int PIX_W     = 8;
	localparam int CFG_W     = 11;
	localparam int ROW_W     = 11;
	localparam int OUT_W     = 10;
	localparam int REG_IDX_W = 2;

	// configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_FILTER_MODE  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

	// filter modes
	localparam logic MODE_BLUR  = 1'b0;
	localparam logic MODE_SOBEL = 1'b1;

	// input action codes
	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_DRAIN = 1'b1;

	// reset frame geometry before clamping
	localparam int RESET_DIM = 256;

	// command queue depth
	localparam int QUEUE_DEPTH = 4;

	// what a transaction asks of the back end
	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_LAST_COL,
		KIND_CENTER
	} kind_t;

	// window borders that fall outside the frame
	typedef struct packed {
		logic top;
		logic bottom;
		logic left;
		logic right;
	} edge_mask_t;

	typedef struct packed {
		kind_t            kind;
		logic [PIX_W-1:0] pixel;
		logic [OUT_W-1:0] row;
		logic [OUT_W-1:0] col;
		logic             frame_end;
		edge_mask_t       mask;
	} cmd_t;

	localparam int CMD_W = $bits(cmd_t);

endpackage

FILE: rtl/sbsf_if.sv
// ----------------------------------------------------------------------------
// sbsf_if: stream channels of the stencil blur/sobel filter
// Input channel carries raster pixels and drain steps, output channel
// carries filtered pixels with their position.
// ----------------------------------------------------------------------------
interface sbsf_in_if import sbsf_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             action;
	logic [PIX_W-1:0] pixel;

	modport source (output valid, output action, output pixel, input ready);
	modport sink (input valid, input action, input pixel, output ready);
endinterface

interface sbsf_out_if import sbsf_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] result_value;
	logic [OUT_W-1:0] out_row;
	logic [OUT_W-1:0] out_col;
	logic             frame_end;

	modport source (output valid, output result_value, output out_row, output out_col,
		output frame_end, input ready);
	modport sink (input valid, input result_value, input out_row, input out_col,
		input frame_end, output ready);
endinterface

FILE: rtl/sbsf_front.sv
// ----------------------------------------------------------------------------
// sbsf_front: raster position tracking and transaction classification
// Keeps the row, column and output counters, decides which window (if any)
// each transaction completes, and pushes one command per transaction.
// ----------------------------------------------------------------------------
module sbsf_front import sbsf_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 1024,
	localparam int DIM_W = $clog2(MAX_WIDTH + 1),
	localparam int HGT_W = $clog2(MAX_HEIGHT + 1),
	localparam int CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1),
	localparam int ADDR_W = $clog2(MAX_WIDTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	sbsf_in_if.sink           pix_in,
	input  logic              clear_busy,
	input  logic [DIM_W-1:0]  width,
	input  logic [HGT_W-1:0]  height,
	input  logic [CNT_W-1:0]  total,
	output logic              push_valid,
	input  logic              push_ready,
	output cmd_t              push_cmd,
	output logic [ADDR_W-1:0] push_addr
);

	logic [ROW_W-1:0] row_q;
	logic [DIM_W-1:0] col_q;
	logic [CNT_W-1:0] emitted_q;

	logic             accept;
	logic             new_frame;
	logic [ROW_W-1:0] row_a;
	logic [DIM_W-1:0] col_a;
	logic [CNT_W-1:0] emitted_a;
	logic             wrap;
	logic [ROW_W-1:0] row_c;
	logic [DIM_W-1:0] col_c;
	logic             is_last;
	logic             is_center;
	logic             emit;
	logic [ROW_W-1:0] o_row;
	logic [DIM_W-1:0] o_col;
	logic             last_item;

	// handshake
	assign pix_in.ready = push_ready && !clear_busy;
	assign push_valid   = pix_in.valid && !clear_busy;
	assign accept       = pix_in.valid && pix_in.ready;

	// position of this transaction
	always_comb begin
		new_frame = emitted_q >= total;
		row_a     = new_frame ? '0 : row_q;
		col_a     = new_frame ? '0 : col_q;
		emitted_a = new_frame ? '0 : emitted_q;
		wrap      = col_a >= width;
		col_c     = wrap ? '0 : col_a;
		row_c     = (wrap && row_a != '1) ? row_a + ROW_W'(1) : row_a;
		is_last   = (col_c == '0) && (row_c >= ROW_W'(2));
		is_center = (col_c != '0) && (row_c != '0);
		emit      = is_last || is_center;
		o_row     = is_last ? row_c - ROW_W'(2) : row_c - ROW_W'(1);
		o_col     = is_last ? width - DIM_W'(1) : col_c - DIM_W'(1);
		last_item = emitted_a == total - CNT_W'(1);
	end

	// command for the back end
	always_comb begin
		if (is_last) begin
			push_cmd.kind = KIND_LAST_COL;
		end else if (is_center) begin
			push_cmd.kind = KIND_CENTER;
		end else begin
			push_cmd.kind = KIND_NONE;
		end
		push_cmd.pixel       = (pix_in.action == ACT_DRAIN) ? '0 : pix_in.pixel;
		push_cmd.row         = OUT_W'(o_row);
		push_cmd.col         = OUT_W'(o_col);
		push_cmd.frame_end   = last_item;
		push_cmd.mask.top    = o_row == '0;
		push_cmd.mask.bottom = (32'(o_row) + 32'd1) >= 32'(height);
		push_cmd.mask.left   = o_col == '0;
		push_cmd.mask.right  = (32'(o_col) + 32'd1) >= 32'(width);
		push_addr            = col_c[ADDR_W-1:0];
	end

	// raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q     <= '0;
			col_q     <= '0;
			emitted_q <= '0;
		end else if (accept) begin
			if (emit && last_item) begin
				row_q     <= '0;
				col_q     <= '0;
				emitted_q <= '0;
			end else begin
				row_q     <= row_c;
				col_q     <= col_c + DIM_W'(1);
				emitted_q <= emitted_a + CNT_W'(emit);
			end
		end
	end

endmodule

FILE: rtl/sbsf_fifo.sv
// ----------------------------------------------------------------------------
// sbsf_fifo: command queue between front and back end
// Small register queue; lets the front keep taking transactions while the
// back end waits on the output.
// ----------------------------------------------------------------------------
module sbsf_fifo import sbsf_pkg::*; #(
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  logic [DATA_W-1:0] push_data,
	output logic              pop_valid,
	input  logic              pop_ready,
	output logic [DATA_W-1:0] pop_data
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

	logic [DATA_W-1:0] store_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [LVL_W-1:0]  level_q;
	logic              push;
	logic              pop;

	assign push_ready = level_q != LVL_W'(QUEUE_DEPTH);
	assign pop_valid  = level_q != '0;
	assign pop_data   = store_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   level_q <= level_q + LVL_W'(1);
				2'b01:   level_q <= level_q - LVL_W'(1);
				default: level_q <= level_q;
			endcase
		end
	end

endmodule

FILE: rtl/sbsf_back.sv
// ----------------------------------------------------------------------------
// sbsf_back: line stores, tap window and kernel datapath
// Reads both line stores, shifts the 3x3 window, applies the edge mask and
// the blur or sobel kernel, and holds the result in the output register.
// ----------------------------------------------------------------------------
module sbsf_back import sbsf_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	localparam int ADDR_W = $clog2(MAX_WIDTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              mode,
	input  logic              pop_valid,
	output logic              pop_ready,
	input  cmd_t              pop_cmd,
	input  logic [ADDR_W-1:0] pop_addr,
	output logic              clear_busy,
	sbsf_out_if.source        res_out
);

	typedef logic [8:0][PIX_W-1:0] window_t;

	// blur: 1-2-1 weighted sum over 16, round half to even
	function automatic logic [PIX_W-1:0] blur_kernel(input window_t w);
		logic [11:0] corners;
		logic [11:0] sides;
		logic [11:0] sum;
		logic [7:0]  quo;
		logic [3:0]  rem;
		logic [8:0]  rounded;
		corners = 12'(w[0]) + 12'(w[2]) + 12'(w[6]) + 12'(w[8]);
		sides   = 12'(w[1]) + 12'(w[3]) + 12'(w[5]) + 12'(w[7]);
		sum     = corners + (sides << 1) + (12'(w[4]) << 2);
		quo     = sum[11:4];
		rem     = sum[3:0];
		rounded = 9'(quo) + 9'((rem > 4'd8) || (rem == 4'd8 && quo[0]));
		return (rounded > 9'd255) ? 8'hFF : rounded[7:0];
	endfunction

	// signed divide by 8, round half to even on the magnitude
	function automatic logic signed [11:0] round_div8(input logic signed [11:0] g);
		logic [11:0] mag;
		logic [11:0] quo;
		logic [2:0]  rem;
		mag = g[11] ? 12'(-g) : 12'(g);
		quo = mag >> 3;
		rem = mag[2:0];
		quo = quo + 12'((rem > 3'd4) || (rem == 3'd4 && quo[0]));
		return g[11] ? -$signed(quo) : $signed(quo);
	endfunction

	// sobel: rounded gx plus rounded gy, clamped
	function automatic logic [PIX_W-1:0] sobel_kernel(input window_t w);
		logic signed [11:0] gx;
		logic signed [11:0] gy;
		logic signed [11:0] v;
		gx = $signed(12'(w[0]) + (12'(w[3]) << 1) + 12'(w[6]))
			- $signed(12'(w[2]) + (12'(w[5]) << 1) + 12'(w[8]));
		gy = $signed(12'(w[0]) + (12'(w[1]) << 1) + 12'(w[2]))
			- $signed(12'(w[6]) + (12'(w[7]) << 1) + 12'(w[8]));
		v  = round_div8(gx) + round_div8(gy);
		if (v < 0) begin
			return '0;
		end else if (v > 12'sd255) begin
			return 8'hFF;
		end else begin
			return v[7:0];
		end
	endfunction

	logic [PIX_W-1:0]  upper_mem [MAX_WIDTH];
	logic [PIX_W-1:0]  middle_mem [MAX_WIDTH];

	logic              clr_busy_q;
	logic [ADDR_W-1:0] clr_addr_q;

	logic              adv;
	logic              take;
	logic              wr_en;

	logic              v_s1;
	cmd_t              cmd_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [PIX_W-1:0]  rd_upper_s1;
	logic [PIX_W-1:0]  rd_middle_s1;
	logic              fwd_s1;
	logic [PIX_W-1:0]  fwd_upper_s1;
	logic [PIX_W-1:0]  fwd_middle_s1;
	logic [PIX_W-1:0]  a_eff;
	logic [PIX_W-1:0]  b_eff;

	window_t           taps_q;
	window_t           win;

	logic              v_s2;
	window_t           win_s2;
	logic [OUT_W-1:0]  row_s2;
	logic [OUT_W-1:0]  col_s2;
	logic              fe_s2;

	logic              out_valid_q;
	logic [PIX_W-1:0]  value_q;
	logic [OUT_W-1:0]  row_q;
	logic [OUT_W-1:0]  col_q;
	logic              fe_q;

	// pipeline advances whenever the output register can take a value
	assign adv        = !out_valid_q || res_out.ready;
	assign pop_ready  = adv && !clr_busy_q;
	assign take       = pop_valid && pop_ready;
	assign wr_en      = adv && v_s1;
	assign clear_busy = clr_busy_q;

	// line store clear sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
			if (clr_addr_q == ADDR_W'(MAX_WIDTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// line stores: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			upper_mem[clr_addr_q]  <= '0;
			middle_mem[clr_addr_q] <= '0;
		end else if (wr_en) begin
			upper_mem[addr_s1]  <= b_eff;
			middle_mem[addr_s1] <= cmd_s1.pixel;
		end
		if (take) begin
			rd_upper_s1  <= upper_mem[pop_addr];
			rd_middle_s1 <= middle_mem[pop_addr];
		end
	end

	// stage 1 command and bypass of a same-address write
	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1        <= pop_cmd;
			addr_s1       <= pop_addr;
			fwd_s1        <= wr_en && (addr_s1 == pop_addr);
			fwd_upper_s1  <= b_eff;
			fwd_middle_s1 <= cmd_s1.pixel;
		end
	end

	assign a_eff = fwd_s1 ? fwd_upper_s1 : rd_upper_s1;
	assign b_eff = fwd_s1 ? fwd_middle_s1 : rd_middle_s1;

	// tap window shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taps_q <= '0;
		end else if (wr_en) begin
			for (int k = 0; k < 3; k++) begin
				taps_q[k*3]     <= taps_q[k*3 + 1];
				taps_q[k*3 + 1] <= taps_q[k*3 + 2];
			end
			taps_q[2] <= a_eff;
			taps_q[5] <= b_eff;
			taps_q[8] <= cmd_s1.pixel;
		end
	end

	// window with edge mask; for the last column the right mask clears column 2
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			win[k*3]     = taps_q[k*3 + 1];
			win[k*3 + 1] = taps_q[k*3 + 2];
		end
		win[2] = a_eff;
		win[5] = b_eff;
		win[8] = cmd_s1.pixel;
		if (cmd_s1.mask.top) begin
			win[0] = '0;
			win[1] = '0;
			win[2] = '0;
		end
		if (cmd_s1.mask.bottom) begin
			win[6] = '0;
			win[7] = '0;
			win[8] = '0;
		end
		if (cmd_s1.mask.left) begin
			win[0] = '0;
			win[3] = '0;
			win[6] = '0;
		end
		if (cmd_s1.mask.right) begin
			win[2] = '0;
			win[5] = '0;
			win[8] = '0;
		end
	end

	// stage valids and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= take;
			v_s2        <= v_s1 && (cmd_s1.kind != KIND_NONE);
			out_valid_q <= v_s2;
		end
	end

	// stage 2 window register
	always_ff @(posedge clk) begin
		if (wr_en) begin
			win_s2 <= win;
			row_s2 <= cmd_s1.row;
			col_s2 <= cmd_s1.col;
			fe_s2  <= cmd_s1.frame_end;
		end
	end

	// kernel into the output register
	always_ff @(posedge clk) begin
		if (adv && v_s2) begin
			case (mode)
				MODE_BLUR:  value_q <= blur_kernel(win_s2);
				MODE_SOBEL: value_q <= sobel_kernel(win_s2);
				default:    value_q <= '0;
			endcase
			row_q <= row_s2;
			col_q <= col_s2;
			fe_q  <= fe_s2;
		end
	end

	assign res_out.valid        = out_valid_q;
	assign res_out.result_value = value_q;
	assign res_out.out_row      = row_q;
	assign res_out.out_col      = col_q;
	assign res_out.frame_end    = fe_q;

endmodule

FILE: rtl/stencil_blur_sobel_filter_core.sv
// ----------------------------------------------------------------------------
// stencil_blur_sobel_filter_core: 3x3 blur / sobel stencil over a pixel stream
// Usage:
//   pix_in takes one transaction per pixel in raster order (action pixel) or
//   a drain step (action drain, pushes a zero). res_out gives at most one
//   filtered pixel per input transaction, with its row, column and a
//   frame_end mark on the last pixel of the frame.
//   A result for a window appears once the transaction that completes it
//   (image_width+1 items later in raster order) has been taken; it passes
//   through the command queue, the stage 1 and stage 2 registers and the output register to res_out.
//   Throughput is one transaction per cycle unless res_out stalls; the
//   line stores take one read and one write per transaction.
//   The cfg port writes filter_mode, image_width and image_height.
//   After reset both line stores are swept to zero, one address a cycle, over
//   all MAX_WIDTH addresses; pix_in.ready stays low during the sweep.
//   When res_out stalls the output register and back pipeline hold, the
//   command queue of 4 entries fills, and then pix_in.ready drops.
// ----------------------------------------------------------------------------
module stencil_blur_sobel_filter_core import sbsf_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	sbsf_in_if.sink              pix_in,
	sbsf_out_if.source           res_out,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int DIM_W   = $clog2(MAX_WIDTH + 1);
	localparam int HGT_W   = $clog2(MAX_HEIGHT + 1);
	localparam int CNT_W   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int ADDR_W  = $clog2(MAX_WIDTH);
	localparam int RST_W   = (RESET_DIM > MAX_WIDTH) ? MAX_WIDTH : RESET_DIM;
	localparam int RST_H   = (RESET_DIM > MAX_HEIGHT) ? MAX_HEIGHT : RESET_DIM;
	localparam int QDATA_W = ADDR_W + CMD_W;

	logic              mode_q;
	logic [DIM_W-1:0]  width_q;
	logic [HGT_W-1:0]  height_q;
	logic [CNT_W-1:0]  total_q;

	logic [31:0]       cfg_ext;
	logic [DIM_W-1:0]  width_new;
	logic [HGT_W-1:0]  height_new;

	logic              clear_busy;
	logic              push_valid;
	logic              push_ready;
	cmd_t              push_cmd;
	logic [ADDR_W-1:0] push_addr;
	logic              pop_valid;
	logic              pop_ready;
	logic [QDATA_W-1:0] pop_data;
	cmd_t              pop_cmd;
	logic [ADDR_W-1:0] pop_addr;

	// geometry clamp: zero reads as one, saturate at the maximum
	assign cfg_ext = 32'(cfg_data);

	always_comb begin
		if (cfg_ext == 32'd0) begin
			width_new = DIM_W'(1);
		end else if (cfg_ext > 32'(MAX_WIDTH)) begin
			width_new = DIM_W'(MAX_WIDTH);
		end else begin
			width_new = DIM_W'(cfg_ext);
		end
		if (cfg_ext == 32'd0) begin
			height_new = HGT_W'(1);
		end else if (cfg_ext > 32'(MAX_HEIGHT)) begin
			height_new = HGT_W'(MAX_HEIGHT);
		end else begin
			height_new = HGT_W'(cfg_ext);
		end
	end

	// configuration registers and frame size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_BLUR;
			width_q  <= DIM_W'(RST_W);
			height_q <= HGT_W'(RST_H);
			total_q  <= CNT_W'(RST_W * RST_H);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FILTER_MODE: begin
					mode_q <= cfg_data[0];
				end
				REG_IMAGE_WIDTH: begin
					width_q <= width_new;
					total_q <= CNT_W'(width_new) * CNT_W'(height_q);
				end
				REG_IMAGE_HEIGHT: begin
					height_q <= height_new;
					total_q  <= CNT_W'(width_q) * CNT_W'(height_new);
				end
				default: begin
				end
			endcase
		end
	end

	// front end
	sbsf_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_in     (pix_in),
		.clear_busy (clear_busy),
		.width      (width_q),
		.height     (height_q),
		.total      (total_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.push_addr  (push_addr)
	);

	// command queue
	sbsf_fifo #(
		.DATA_W (QDATA_W)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  ({push_addr, push_cmd}),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	assign pop_addr = pop_data[QDATA_W-1 -: ADDR_W];
	assign pop_cmd  = cmd_t'(pop_data[CMD_W-1:0]);

	// back end
	sbsf_back #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.mode       (mode_q),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd),
		.pop_addr   (pop_addr),
		.clear_busy (clear_busy),
		.res_out    (res_out)
	);

	// no transaction is taken while the line stores are being cleared
	assert property (@(posedge clk) disable iff (!arst_n) clear_busy |-> !pix_in.ready)
		else $error("input taken during line store clear");

	// no result can be pending during the clear sweep
	assert property (@(posedge clk) disable iff (!arst_n) res_out.valid |-> !clear_busy)
		else $error("result present during line store clear");

	// frame size tracks the geometry registers
	assert property (@(posedge clk) disable iff (!arst_n)
		total_q == CNT_W'(width_q) * CNT_W'(height_q))
		else $error("frame size out of step with geometry");

endmodule
